/* rtl/sqwl_pkg.sv */
package sqwl_pkg;

    localparam int DEPTH       = 32;
    localparam int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W     = $clog2(DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int POS_W       = 5;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 2;
    localparam int OUT_TDATA_W = ((DATA_W + POS_W + 7) / 8) * 8;

    localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
    localparam logic [OP_W-1:0] OP_POP  = 2'd1;
    localparam logic [OP_W-1:0] OP_LIST = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [COUNT_W-1:0] t_count;

endpackage

/* rtl/shift_queue_with_listing.sv */
// Push and a full-queue or empty-queue report: result is registered the cycle after acceptance.
// Pop: the entry memory read is registered, then the result loads once the output is free.
// List of N entries: first entry after the registered memory read, then one entry per cycle while
// the output is free; input is held off until the last entry has been loaded into the output register.
// With the output ready, a push or report is taken every cycle; a pop or list holds off new input.
// Reset (synchronous, active low) empties the queue; entry memory contents are not cleared.
module shift_queue_with_listing (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [sqwl_pkg::DATA_W-1:0]     s_axis_tdata,  // push_value[31:0]
    input  logic [sqwl_pkg::OP_W-1:0]       s_axis_tuser,  // opcode[1:0]
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [sqwl_pkg::OUT_TDATA_W-1:0] m_axis_tdata, // data_value[31:0], position[36:32], zero pad
    output logic [sqwl_pkg::STATUS_W-1:0]   m_axis_tuser,  // status[1:0]
    output logic                            m_axis_tlast   // last_result
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_LIST = 2'd2;

    logic [1:0]              r_state, n_state;
    sqwl_pkg::t_addr         r_head, n_head;
    sqwl_pkg::t_count        r_count, n_count;
    sqwl_pkg::t_addr         r_rd_ptr, n_rd_ptr;
    sqwl_pkg::t_count        r_pos, n_pos;

    logic                            r_out_valid, n_out_valid;
    logic [sqwl_pkg::STATUS_W-1:0]   r_out_status, n_out_status;
    logic [sqwl_pkg::DATA_W-1:0]     r_out_data, n_out_data;
    logic [sqwl_pkg::POS_W-1:0]      r_out_pos, n_out_pos;
    logic                            r_out_last, n_out_last;

    logic                        in_acc;
    logic                        out_free;
    logic                        ram_we;
    sqwl_pkg::t_addr             tail;
    logic [sqwl_pkg::ADDR_W:0]   tail_sum;
    logic [sqwl_pkg::DATA_W-1:0] ram_rdata;
    logic                        list_last;

    function automatic sqwl_pkg::t_addr ptr_inc(input sqwl_pkg::t_addr p);
        if (p == sqwl_pkg::ADDR_W'(sqwl_pkg::DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && out_free;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // Tail is head plus count, wrapped once around the ring.
    assign tail_sum = {1'b0, r_head} + (sqwl_pkg::ADDR_W + 1)'(r_count);
    assign tail = (tail_sum >= (sqwl_pkg::ADDR_W + 1)'(sqwl_pkg::DEPTH))
                ? sqwl_pkg::ADDR_W'(tail_sum - (sqwl_pkg::ADDR_W + 1)'(sqwl_pkg::DEPTH))
                : tail_sum[sqwl_pkg::ADDR_W-1:0];

    assign ram_we    = in_acc && (s_axis_tuser == sqwl_pkg::OP_PUSH)
                     && (r_count != sqwl_pkg::COUNT_W'(sqwl_pkg::DEPTH));
    assign list_last = (r_pos + 1'b1) == r_count;

    sqwl_ram #(
        .DEPTH(sqwl_pkg::DEPTH),
        .WIDTH(sqwl_pkg::DATA_W)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(tail),
        .i_wdata(s_axis_tdata),
        .i_raddr(n_rd_ptr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_count      = r_count;
        n_rd_ptr     = r_rd_ptr;
        n_pos        = r_pos;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_status = r_out_status;
        n_out_data   = r_out_data;
        n_out_pos    = r_out_pos;
        n_out_last   = r_out_last;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_out_status = sqwl_pkg::ST_OK;
                    n_out_data   = '0;
                    n_out_pos    = '0;
                    n_out_last   = 1'b1;
                    unique case (s_axis_tuser) inside
                        sqwl_pkg::OP_PUSH: begin
                            n_out_valid = 1'b1;
                            if (ram_we) begin
                                n_count = r_count + 1'b1;
                            end else begin
                                n_out_status = sqwl_pkg::ST_FULL;
                            end
                        end
                        sqwl_pkg::OP_POP, sqwl_pkg::OP_LIST: begin
                            if (r_count == '0) begin
                                n_out_valid  = 1'b1;
                                n_out_status = sqwl_pkg::ST_EMPTY;
                            end else begin
                                n_rd_ptr = r_head;
                                n_pos    = '0;
                                n_state  = (s_axis_tuser == sqwl_pkg::OP_POP) ? S_POP : S_LIST;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_POP: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = sqwl_pkg::ST_OK;
                    n_out_data   = ram_rdata;
                    n_out_pos    = '0;
                    n_out_last   = 1'b1;
                    n_head       = ptr_inc(r_head);
                    n_count      = r_count - 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_LIST: begin
                // The read address follows the next pointer, so the memory output
                // always holds the entry at r_rd_ptr.
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = sqwl_pkg::ST_OK;
                    n_out_data   = ram_rdata;
                    n_out_pos    = r_pos[sqwl_pkg::POS_W-1:0];
                    n_out_last   = list_last;
                    n_rd_ptr     = ptr_inc(r_rd_ptr);
                    n_pos        = r_pos + 1'b1;
                    if (list_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_rd_ptr    <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_rd_ptr    <= n_rd_ptr;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_status <= n_out_status;
        r_out_data   <= n_out_data;
        r_out_pos    <= n_out_pos;
        r_out_last   <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = sqwl_pkg::OUT_TDATA_W'({r_out_pos, r_out_data});

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= sqwl_pkg::COUNT_W'(sqwl_pkg::DEPTH))
        else $error("entry count exceeds queue depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> (r_count == $past(r_count) + 1'b1) && m_axis_tvalid)
        else $error("accepted push did not grow the queue");

    a_nonlast_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (r_state == S_LIST))
        else $error("non-final result outside a listing");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP && out_free) |=> r_count == $past(r_count) - 1'b1)
        else $error("completed pop did not shrink the queue");

endmodule

/* rtl/sqwl_ram.sv */
module sqwl_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* dv/shift_queue_with_listing_tb.sv */
module shift_queue_with_listing_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [sqwl_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int NUM_ITEMS = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES = 20;

    typedef struct {
        logic [sqwl_pkg::OP_W-1:0]   op;
        logic [sqwl_pkg::DATA_W-1:0] value;
        bit                          drain_first;  // hold this item until every result is back
    } t_queued_item;

    typedef struct {
        logic [sqwl_pkg::STATUS_W-1:0] status;
        logic [sqwl_pkg::DATA_W-1:0]   data_value;
        logic [sqwl_pkg::POS_W-1:0]    position;
        logic                          last;
    } t_queue_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [sqwl_pkg::DATA_W-1:0] s_axis_tdata = '0;   // push_value[31:0]
    logic [sqwl_pkg::OP_W-1:0] s_axis_tuser = '0;     // opcode[1:0]
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [sqwl_pkg::OUT_TDATA_W-1:0] m_axis_tdata;   // data_value[31:0], position[36:32], zero pad
    logic [sqwl_pkg::STATUS_W-1:0] m_axis_tuser;      // status[1:0]
    logic m_axis_tlast;                               // last_result

    t_queued_item pending_items[$];
    t_queue_result expected_results[$];
    logic [sqwl_pkg::DATA_W-1:0] held_values[$];

    int gen_count = 0;
    int n_items = 0;
    int items_accepted = 0;
    int errors = 0;
    int idle_cycles = 0;
    int gap_left = 0;
    int burst_left = 1;
    int window_left = 0;
    int rx_mode = 0;

    shift_queue_with_listing dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Applies one accepted item to the queue copy and records the results it causes.
    task automatic predict_queue_op(input logic [sqwl_pkg::OP_W-1:0] op,
                                    input logic [sqwl_pkg::DATA_W-1:0] value);
        t_queue_result r;
        int i;
        r.status = sqwl_pkg::ST_OK;
        r.data_value = '0;
        r.position = '0;
        r.last = 1'b1;
        case (op)
            sqwl_pkg::OP_PUSH: begin
                if (held_values.size() >= sqwl_pkg::DEPTH) begin
                    r.status = sqwl_pkg::ST_FULL;
                end else begin
                    held_values.push_back(value);
                end
                expected_results.push_back(r);
            end
            sqwl_pkg::OP_POP: begin
                if (held_values.size() == 0) begin
                    r.status = sqwl_pkg::ST_EMPTY;
                end else begin
                    r.data_value = held_values.pop_front();
                end
                expected_results.push_back(r);
            end
            sqwl_pkg::OP_LIST: begin
                if (held_values.size() == 0) begin
                    r.status = sqwl_pkg::ST_EMPTY;
                    expected_results.push_back(r);
                end else begin
                    for (i = 0; i < held_values.size(); i++) begin
                        r.data_value = held_values[i];
                        r.position = i[sqwl_pkg::POS_W-1:0];
                        r.last = (i == held_values.size() - 1);
                        expected_results.push_back(r);
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic add_item(input logic [sqwl_pkg::OP_W-1:0] op,
                            input logic [sqwl_pkg::DATA_W-1:0] value,
                            input bit drain_first);
        t_queued_item it;
        it.op = op;
        it.value = value;
        it.drain_first = drain_first;
        pending_items.push_back(it);
        n_items++;
        if (op == sqwl_pkg::OP_PUSH && gen_count < sqwl_pkg::DEPTH) begin
            gen_count++;
        end else if (op == sqwl_pkg::OP_POP && gen_count > 0) begin
            gen_count--;
        end
    endtask

    function automatic logic [sqwl_pkg::DATA_W-1:0] pick_value();
        logic [sqwl_pkg::DATA_W-1:0] v;
        case ($urandom_range(0, 15))
            0: v = 32'h8000_0000;
            1: v = 32'h7fff_ffff;
            2: v = 32'h0000_0000;
            3: v = 32'hffff_ffff;
            4: v = -32'sd999999;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Stimulus and end of run.
    initial begin
        int seg;
        int k;
        int pick;

        // Directed part: empty reports, the old sentinel value, extremes, unused opcode.
        add_item(sqwl_pkg::OP_LIST, 32'h0, 1'b0);
        add_item(sqwl_pkg::OP_POP, 32'hffff_ffff, 1'b0);
        add_item(sqwl_pkg::OP_PUSH, -32'sd999999, 1'b0);
        add_item(sqwl_pkg::OP_LIST, 32'h0, 1'b0);
        add_item(sqwl_pkg::OP_POP, 32'h0, 1'b0);
        add_item(sqwl_pkg::OP_POP, 32'h0, 1'b0);
        add_item(sqwl_pkg::OP_PUSH, 32'h8000_0000, 1'b0);
        add_item(sqwl_pkg::OP_PUSH, 32'h7fff_ffff, 1'b0);
        add_item(sqwl_pkg::OP_PUSH, 32'h0000_0000, 1'b0);
        add_item(sqwl_pkg::OP_PUSH, 32'hffff_ffff, 1'b0);
        add_item(OP_UNUSED, 32'hffff_ffff, 1'b0);
        add_item(sqwl_pkg::OP_LIST, 32'hffff_ffff, 1'b0);
        add_item(sqwl_pkg::OP_POP, 32'h0, 1'b0);
        add_item(OP_UNUSED, 32'h0, 1'b0);
        add_item(sqwl_pkg::OP_PUSH, 32'h5555_5555, 1'b0);
        add_item(sqwl_pkg::OP_PUSH, 32'haaaa_aaaa, 1'b0);
        add_item(sqwl_pkg::OP_LIST, 32'h0, 1'b1);
        add_item(sqwl_pkg::OP_POP, 32'h0, 1'b0);
        add_item(sqwl_pkg::OP_POP, 32'h0, 1'b0);
        add_item(sqwl_pkg::OP_POP, 32'h0, 1'b0);
        add_item(sqwl_pkg::OP_LIST, 32'h0, 1'b0);

        // Random part: fill to full, drain to empty and mixed stretches.
        seg = 0;
        while (n_items < NUM_ITEMS) begin
            pick = (seg < 2) ? seg : $urandom_range(0, 3);
            seg++;
            case (pick)
                0: begin
                    add_item(sqwl_pkg::OP_PUSH, pick_value(), $urandom_range(0, 4) == 0);
                    while (gen_count < sqwl_pkg::DEPTH) begin
                        add_item(sqwl_pkg::OP_PUSH, pick_value(), 1'b0);
                    end
                    repeat ($urandom_range(1, 2)) add_item(sqwl_pkg::OP_PUSH, pick_value(), 1'b0);
                    add_item(sqwl_pkg::OP_LIST, $urandom, 1'b0);
                end
                1: begin
                    add_item(sqwl_pkg::OP_POP, $urandom, $urandom_range(0, 4) == 0);
                    while (gen_count > 0) begin
                        if ($urandom_range(0, 9) == 0) begin
                            add_item(sqwl_pkg::OP_LIST, $urandom, 1'b0);
                        end else begin
                            add_item(sqwl_pkg::OP_POP, $urandom, 1'b0);
                        end
                    end
                    add_item(sqwl_pkg::OP_POP, $urandom, 1'b0);
                    add_item(sqwl_pkg::OP_LIST, $urandom, 1'b0);
                end
                default: begin
                    for (k = 0; k < $urandom_range(10, 30); k++) begin
                        case ($urandom_range(0, 19))
                            0, 1, 2, 3, 4, 5, 6, 7, 8:
                                add_item(sqwl_pkg::OP_PUSH, pick_value(), 1'b0);
                            9, 10, 11, 12, 13, 14, 15:
                                add_item(sqwl_pkg::OP_POP, $urandom, 1'b0);
                            16, 17, 18: add_item(sqwl_pkg::OP_LIST, $urandom, 1'b0);
                            default: add_item(OP_UNUSED, $urandom, 1'b0);
                        endcase
                    end
                end
            endcase
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (items_accepted != n_items) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (errors == 0 && expected_results.size() == 0) begin
            $display("shift_queue_with_listing verification clean");
        end else begin
            $display("shift_queue_with_listing verification failed");
        end
        $finish;
    end

    // Sender: bursts of items with random gaps, held while not accepted.
    always @(posedge i_clk) begin : drive
        t_queued_item it;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            gap_left <= 0;
            burst_left <= 1;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_queue_op(s_axis_tuser, s_axis_tdata);
                items_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_items.size() != 0 &&
                             !(pending_items[0].drain_first &&
                               expected_results.size() != 0)) begin
                    it = pending_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= it.op;
                    s_axis_tdata <= it.value;
                    if (burst_left <= 1) begin
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                        burst_left <= ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                                  : $urandom_range(1, 12);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall pattern: windows of always-ready, light, heavy and coin-flip stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            window_left <= 0;
            rx_mode <= 0;
        end else begin
            if (window_left == 0) begin
                window_left <= $urandom_range(20, 80);
                rx_mode <= $urandom_range(0, 3);
            end else begin
                window_left <= window_left - 1;
            end
            case (rx_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= $urandom_range(0, 1);
                2: m_axis_tready <= ($urandom_range(0, 7) != 0);
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Checks each result item against the oldest expectation.
    always @(posedge i_clk) begin : check
        t_queue_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, actual status %0d data %h pos %0d last %0b",
                         $time, m_axis_tuser, m_axis_tdata[sqwl_pkg::DATA_W-1:0],
                         m_axis_tdata[sqwl_pkg::DATA_W+sqwl_pkg::POS_W-1:sqwl_pkg::DATA_W],
                         m_axis_tlast);
            end else begin
                want = expected_results.pop_front();
                if (m_axis_tuser !== want.status) begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, m_axis_tuser);
                end
                if (m_axis_tdata[sqwl_pkg::DATA_W-1:0] !== want.data_value) begin
                    errors++;
                    $display("%0t: data_value expected %h actual %h",
                             $time, want.data_value, m_axis_tdata[sqwl_pkg::DATA_W-1:0]);
                end
                if (m_axis_tdata[sqwl_pkg::DATA_W+sqwl_pkg::POS_W-1:sqwl_pkg::DATA_W]
                    !== want.position) begin
                    errors++;
                    $display("%0t: position expected %0d actual %0d",
                             $time, want.position,
                             m_axis_tdata[sqwl_pkg::DATA_W+sqwl_pkg::POS_W-1:sqwl_pkg::DATA_W]);
                end
                if (m_axis_tlast !== want.last) begin
                    errors++;
                    $display("%0t: last_result expected %0b actual %0b",
                             $time, want.last, m_axis_tlast);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("shift_queue_with_listing verification failed");
        $finish;
    end

endmodule
